// ----- hdl/mf3_pkg.sv -----
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared types and constants of the 3x3 median filter: configuration register
// indexes, reset values and the pixel, column and line store entry types.
// ----------------------------------------------------------------------------
package mf3_pkg;

  localparam int CFG_DATA_W = 11;
  localparam int CFG_ADDR_W = 1;
  localparam int PIXEL_W    = 8;
  localparam int MIN_DIM    = 3;
  localparam int WIN_BORDER = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam logic [CFG_DATA_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
  localparam logic [CFG_DATA_W-1:0] IMAGE_HEIGHT_RST = 11'd480;

  typedef logic [PIXEL_W-1:0] pixel_t;

  // one window column, held sorted
  typedef struct packed {
    pixel_t hi;
    pixel_t md;
    pixel_t lo;
  } column_t;

  // line store entry: two rows back and one row back
  typedef struct packed {
    pixel_t up2;
    pixel_t up1;
  } line_pair_t;

endpackage

// ----- hdl/median_filter_3x3.sv -----
// ----------------------------------------------------------------------------
// median_filter_3x3
// Streaming 3x3 median filter for 8-bit grey frames in raster order.
// ----------------------------------------------------------------------------
// Pixels enter on the s_ stream: s_tdata carries the grey value, s_tuser marks
// row 0 column 0 of a frame and forces the position counters back to zero.
// Frame width and height are written through cfg_we/cfg_addr/cfg_wdata; the
// user must write them only while the block is idle, which the block does not
// enforce. Values are clamped to 3 .. MAX_WIDTH / MAX_HEIGHT. Each pixel at
// row >= 2 and column >= 2 closes the window of the interior pixel up and left
// of it, and one median word leaves on the m_ stream, with m_tlast on the last
// interior pixel of the frame. Border pixels give nothing. One pixel is taken
// every clock while the output is not stalled. The median reaches m_tdata
// through the line store read at the taking edge, the column sort into the
// window and the median of the three sorted columns into the output register.
// The line store is a single memory of MAX_WIDTH entries, read and written
// once a cycle. Reset clears the counters, valid flags and window and loads
// 640 x 480; the line store and m_tdata/m_tlast are not cleared. While m_tvalid
// is high and m_tready low the whole pipeline holds and s_tready is low.
// ----------------------------------------------------------------------------
module median_filter_3x3 import mf3_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // pixel
  input  logic                  s_tuser,   // frame_start
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // median
  output logic                  m_tlast,   // frame_last
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  function automatic pixel_t max2(input pixel_t a, input pixel_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic pixel_t min2(input pixel_t a, input pixel_t b);
    return (a > b) ? b : a;
  endfunction

  function automatic pixel_t med3(input pixel_t a, input pixel_t b, input pixel_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic column_t sort3(input pixel_t a, input pixel_t b, input pixel_t c);
    column_t r;
    r.lo = min2(min2(a, b), c);
    r.hi = max2(max2(a, b), c);
    r.md = med3(a, b, c);
    return r;
  endfunction

  logic [CFG_DATA_W-1:0] image_width;
  logic [CFG_DATA_W-1:0] image_height;
  logic [WW-1:0]         w_eff;
  logic [HW-1:0]         h_eff;

  logic [CW-1:0] col_cnt, col_cnt_next;
  logic [RW-1:0] row_cnt, row_cnt_next;
  logic [CW-1:0] col_in, col_cur;
  logic [RW-1:0] row_in, row_cur;
  logic [HW-1:0] row_inc;
  logic          col_wrap, col_end, row_end, cur_emit, cur_last;

  logic en, accept;

  line_pair_t line_mem [MAX_WIDTH];
  line_pair_t rd_pair;
  line_pair_t pair_eff;
  line_pair_t wr_pair;

  logic       s1_valid;
  pixel_t     s1_px;
  logic [CW-1:0] s1_col;
  logic       s1_emit;
  logic       s1_last;
  logic       s1_fwd;
  line_pair_t s1_fwd_pair;
  column_t    new_col;

  column_t    win [3];
  logic       s2_valid;
  logic       s2_emit;
  logic       s2_last;
  pixel_t     median;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RST;
      image_height <= IMAGE_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_IMAGE_WIDTH:  image_width  <= cfg_wdata;
        REG_IMAGE_HEIGHT: image_height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width < CFG_DATA_W'(MIN_DIM)) w_eff = WW'(MIN_DIM);
    else if (int'(image_width) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(image_width);
    if (image_height < CFG_DATA_W'(MIN_DIM)) h_eff = HW'(MIN_DIM);
    else if (int'(image_height) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(image_height);
  end

  // position of the incoming pixel
  always_comb begin
    col_in   = s_tuser ? '0 : col_cnt;
    row_in   = s_tuser ? '0 : row_cnt;
    col_wrap = WW'(col_in) >= w_eff;
    col_cur  = col_wrap ? '0 : col_in;
    row_inc  = col_wrap ? HW'(row_in) + HW'(1) : HW'(row_in);
    row_cur  = (row_inc >= h_eff) ? '0 : row_inc[RW-1:0];
    col_end  = WW'(col_cur) == w_eff - WW'(1);
    row_end  = HW'(row_cur) == h_eff - HW'(1);
    cur_emit = (row_cur >= RW'(WIN_BORDER)) && (col_cur >= CW'(WIN_BORDER));
    cur_last = row_end && col_end;
    if (col_end) begin
      col_cnt_next = '0;
      row_cnt_next = row_end ? '0 : row_cur + RW'(1);
    end else begin
      col_cnt_next = col_cur + CW'(1);
      row_cnt_next = row_cur;
    end
  end

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign accept   = s_tvalid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      col_cnt <= col_cnt_next;
      row_cnt <= row_cnt_next;
    end
  end

  // line store
  assign pair_eff    = s1_fwd ? s1_fwd_pair : rd_pair;
  assign wr_pair.up2 = pair_eff.up1;
  assign wr_pair.up1 = s1_px;

  always_ff @(posedge clk) begin
    if (accept) rd_pair <= line_mem[col_cur];
    if (en && s1_valid) line_mem[s1_col] <= wr_pair;
  end

  // stage 1: pixel and its column
  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (en) s1_valid <= accept;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px       <= s_tdata;
      s1_col      <= col_cur;
      s1_emit     <= cur_emit;
      s1_last     <= cur_last;
      s1_fwd      <= s1_valid && (s1_col == col_cur);
      s1_fwd_pair <= wr_pair;
    end
  end

  assign new_col = sort3(pair_eff.up2, pair_eff.up1, s1_px);

  // stage 2: window of sorted columns
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      for (int i = 0; i < 3; i++) win[i] <= '0;
    end else if (en) begin
      s2_valid <= s1_valid;
      if (s1_valid) begin
        win[0] <= win[1];
        win[1] <= win[2];
        win[2] <= new_col;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_valid) begin
      s2_emit <= s1_emit;
      s2_last <= s1_last;
    end
  end

  assign median = med3(max2(max2(win[0].lo, win[1].lo), win[2].lo),
                       med3(win[0].md, win[1].md, win[2].md),
                       min2(min2(win[0].hi, win[1].hi), win[2].hi));

  // output register
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= s2_valid && s2_emit;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= median;
      m_tlast <= s2_last;
    end
  end

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s2_valid && s2_emit))
    else $error("result without an interior pixel");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> col_cnt == CW'(1) && row_cnt == '0)
    else $error("counters not resynchronised by frame start");
`endif

endmodule
